### rtl/crkm_pkg.sv
// Shared types, constants and the microprogram of the challenge-response key mixer.
// Depends on nothing. The sequencer and the top level both use it.
package crkm_pkg;

   // Modulus 2^31-1 and the fixed word multiplier
   localparam logic [30:0] MixPrime = 31'h7FFFFFFF;
   localparam logic [30:0] MixMult  = 31'h0E79A9C1;

   // Step counter width, enough for the whole program
   localparam int StepWidth = 5;

   typedef enum logic [0:0] {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_MUL_W0,
      OP_FOLD,
      OP_FINISH,
      OP_ADD_HIGH,
      OP_MUL_K0,
      OP_ADD_K1,
      OP_ADD_W1,
      OP_MUL_K2,
      OP_ADD_K3,
      OP_ACC_SUM,
      OP_LOAD_HF,
      OP_LOAD_SF,
      OP_EMIT
   } mix_op_type;

   // One control word
   typedef struct packed {
      mix_op_type op;
      logic       st_t;        // store reduced value as t
      logic       st_h;        // store reduced value as running high
      logic       st_hf;       // store reduced value as final high
      logic       done_no_end; // leave program when the pair is not the last one
      logic       done;        // leave program unconditionally
   } ucode_type;

   // Byte swap of a 32-bit word
   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Key derivation: byte-swapped chunk masked to 31 bits
   function automatic logic [30:0] derive_key(input logic [31:0] chunk);
      logic [31:0] s;
      s = swap32(chunk);
      return s[30:0];
   endfunction

   // Program ROM
   function automatic ucode_type ucode_rom(input logic [StepWidth-1:0] step);
      ucode_type w;
      w = '0;
      w.op = OP_NOP;
      case (step)
         5'd0:  w.op = OP_MUL_W0;
         5'd1:  w.op = OP_FOLD;
         5'd2:  w.op = OP_FINISH;
         5'd3:  w.op = OP_ADD_HIGH;
         5'd4:  w.op = OP_MUL_K0;
         5'd5:  w.op = OP_ADD_K1;
         5'd6:  w.op = OP_FOLD;
         5'd7:  begin
            w.op   = OP_FINISH;
            w.st_t = 1'b1;
         end
         5'd8:  w.op = OP_ADD_W1;
         5'd9:  w.op = OP_FOLD;
         5'd10: w.op = OP_FINISH;
         5'd11: w.op = OP_MUL_K2;
         5'd12: w.op = OP_ADD_K3;
         5'd13: w.op = OP_FOLD;
         5'd14: begin
            w.op   = OP_FINISH;
            w.st_h = 1'b1;
         end
         5'd15: begin
            w.op          = OP_ACC_SUM;
            w.done_no_end = 1'b1;
         end
         5'd16: w.op = OP_LOAD_HF;
         5'd17: w.op = OP_FOLD;
         5'd18: begin
            w.op    = OP_FINISH;
            w.st_hf = 1'b1;
         end
         5'd19: w.op = OP_LOAD_SF;
         5'd20: w.op = OP_FOLD;
         5'd21: w.op = OP_FINISH;
         5'd22: begin
            w.op   = OP_EMIT;
            w.done = 1'b1;
         end
         default: w.done = 1'b1;
      endcase
      return w;
   endfunction

endpackage

### rtl/crkm_seq.sv
// Microcode sequencer of the key mixer: step counter, program ROM and run/idle control.
// Depends on crkm_pkg.
module crkm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                run_end,
   input  logic                out_busy,
   output crkm_pkg::ucode_type ctrl,
   output logic                busy
);

   crkm_pkg::seq_state_type state_ff, state_in;
   logic [crkm_pkg::StepWidth-1:0] step_ff, step_in;
   crkm_pkg::ucode_type word;
   logic hold;
   logic leave;

   // Current control word; emit waits while the result register is full
   assign word  = crkm_pkg::ucode_rom(step_ff);
   assign hold  = (word.op == crkm_pkg::OP_EMIT) && out_busy;
   assign leave = !hold && (word.done || (word.done_no_end && !run_end));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crkm_pkg::SEQ_IDLE: begin
            if (start) state_in = crkm_pkg::SEQ_RUN;
         end
         crkm_pkg::SEQ_RUN: begin
            if (leave) state_in = crkm_pkg::SEQ_IDLE;
         end
         default: state_in = crkm_pkg::SEQ_IDLE;
      endcase
   end

   // Outputs and step advance
   always_comb begin
      ctrl    = '0;
      ctrl.op = crkm_pkg::OP_NOP;
      busy    = 1'b1;
      step_in = step_ff;
      case (state_ff)
         crkm_pkg::SEQ_IDLE: begin
            busy    = 1'b0;
            step_in = '0;
         end
         crkm_pkg::SEQ_RUN: begin
            if (!hold) begin
               ctrl    = word;
               step_in = step_ff + {{(crkm_pkg::StepWidth-1){1'b0}}, 1'b1};
            end
         end
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crkm_pkg::SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/challenge_response_key_mixer.sv
// Challenge-response key mixer: chained multiply and mod 2^31-1 updates over word pairs.
// Each pair runs the microprogram: a pair that is not the last leaves after the sum step,
// a last pair goes on through the final folds to the emit, which registers the result.
// No transaction is taken while it runs; one shared 32x31 multiplier, a two-step fold.
// Reset is synchronous: keys, held digest, chain values, sequencer and rsp_valid clear.
// Depends on crkm_pkg and crkm_seq.
module challenge_response_key_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_digest_upper,
   input  logic [63:0] req_digest_lower,
   input  logic [30:0] req_word_first,
   input  logic [30:0] req_word_second,
   input  logic        req_run_start,
   input  logic        req_run_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_response_upper,
   output logic [63:0] rsp_response_lower
);

   crkm_pkg::ucode_type ctrl;
   logic busy;
   logic accept;

   logic [30:0] key0_ff, key1_ff, key2_ff, key3_ff;
   logic [63:0] held_upper_ff, held_lower_ff;
   logic [30:0] chain_high_ff, chain_high_in;
   logic [63:0] chain_sum_ff, chain_sum_in;
   logic [30:0] w0_ff, w1_ff;
   logic        end_ff;
   logic [63:0] acc_ff, acc_in;
   logic [30:0] tval_ff, hf_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_upper_ff, rsp_lower_ff;

   logic [31:0] mul_a;
   logic [30:0] mul_b;
   logic [62:0] mul_p;
   logic [32:0] fold_sum;
   logic [31:0] fin_sum;
   logic [30:0] fin_res;
   logic [63:0] mixed;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy;

   crkm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .run_end  (end_ff),
      .out_busy (rsp_valid_ff && rsp_stall),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   // Shared multiplier
   always_comb begin
      mul_a = acc_ff[31:0];
      mul_b = key0_ff;
      case (ctrl.op)
         crkm_pkg::OP_MUL_W0: begin
            mul_a = {1'b0, w0_ff};
            mul_b = crkm_pkg::MixPrime & crkm_pkg::MixMult;
         end
         crkm_pkg::OP_MUL_K2: mul_b = key2_ff;
         default: mul_b = key0_ff;
      endcase
   end
   assign mul_p = 63'(mul_a) * 63'(mul_b);

   // Modulo 2^31-1: fold 64 bits to 33, then fold again with one conditional subtract
   assign fold_sum = 33'(acc_ff[30:0]) + 33'(acc_ff[61:31]) + 33'(acc_ff[63:62]);
   assign fin_sum  = 32'(acc_ff[30:0]) + 32'(acc_ff[32:31]);
   assign fin_res  = (fin_sum >= 32'(crkm_pkg::MixPrime))
                     ? 31'(fin_sum - 32'(crkm_pkg::MixPrime)) : fin_sum[30:0];

   // Final key from byte-swapped high and sum
   assign mixed = {crkm_pkg::swap32({1'b0, hf_ff}), crkm_pkg::swap32({1'b0, acc_ff[30:0]})};

   // Accumulator datapath
   always_comb begin
      acc_in       = acc_ff;
      chain_sum_in = chain_sum_ff;
      case (ctrl.op)
         crkm_pkg::OP_MUL_W0,
         crkm_pkg::OP_MUL_K0,
         crkm_pkg::OP_MUL_K2:  acc_in = 64'(mul_p);
         crkm_pkg::OP_FOLD:    acc_in = 64'(fold_sum);
         crkm_pkg::OP_FINISH:  acc_in = 64'(fin_res);
         crkm_pkg::OP_ADD_HIGH: acc_in = acc_ff + 64'(chain_high_ff);
         crkm_pkg::OP_ADD_K1:  acc_in = acc_ff + 64'(key1_ff);
         crkm_pkg::OP_ADD_W1:  acc_in = acc_ff + 64'(w1_ff);
         crkm_pkg::OP_ADD_K3:  acc_in = acc_ff + 64'(key3_ff);
         crkm_pkg::OP_ACC_SUM: chain_sum_in = chain_sum_ff
                                  + 64'(33'(acc_ff[30:0]) + 33'(tval_ff));
         crkm_pkg::OP_LOAD_HF: acc_in = 64'(chain_high_ff) + 64'(key1_ff);
         crkm_pkg::OP_LOAD_SF: acc_in = chain_sum_ff + 64'(key3_ff);
         default: acc_in = acc_ff;
      endcase
   end

   // Running high: cleared at run start, else updated by the program
   always_comb begin
      chain_high_in = chain_high_ff;
      if (ctrl.st_h) chain_high_in = fin_res;
   end

   // Per-run state and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff       <= '0;
         key1_ff       <= '0;
         key2_ff       <= '0;
         key3_ff       <= '0;
         held_upper_ff <= '0;
         held_lower_ff <= '0;
         chain_high_ff <= '0;
         chain_sum_ff  <= '0;
         end_ff        <= 1'b0;
      end else if (accept) begin
         end_ff <= req_run_end;
         if (req_run_start) begin
            held_upper_ff <= req_digest_upper;
            held_lower_ff <= req_digest_lower;
            key0_ff       <= crkm_pkg::derive_key(req_digest_upper[63:32]);
            key1_ff       <= crkm_pkg::derive_key(req_digest_upper[31:0]);
            key2_ff       <= crkm_pkg::derive_key(req_digest_lower[63:32]);
            key3_ff       <= crkm_pkg::derive_key(req_digest_lower[31:0]);
            chain_high_ff <= '0;
            chain_sum_ff  <= '0;
         end
      end else begin
         chain_high_ff <= chain_high_in;
         chain_sum_ff  <= chain_sum_in;
      end
   end

   // Payload registers of the datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         w0_ff <= req_word_first;
         w1_ff <= req_word_second;
      end
      acc_ff <= acc_in;
      if (ctrl.st_t)  tval_ff <= fin_res;
      if (ctrl.st_hf) hf_ff   <= fin_res;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.op == crkm_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == crkm_pkg::OP_EMIT) begin
         rsp_upper_ff <= held_upper_ff ^ mixed;
         rsp_lower_ff <= held_lower_ff ^ mixed;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_response_upper = rsp_upper_ff;
   assign rsp_response_lower = rsp_lower_ff;

   // Running high stays a proper residue
   a_high_residue: assert property (@(posedge clock) disable iff (reset)
      chain_high_ff != crkm_pkg::MixPrime)
      else $error("running high reached the modulus");

   // A new result only follows a last pair
   a_emit_on_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> end_ff)
      else $error("result without a last pair");

   // No transaction is taken while the program runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op != crkm_pkg::OP_NOP) |-> !accept)
      else $error("transaction accepted during program");

endmodule

### bench/challenge_response_key_mixer_tb.sv
// Self-checking bench for the challenge-response key mixer: drives runs of word pairs and
// checks every response against an in-bench model of the chained mod 2^31-1 key mixing.
// Depends on crkm_pkg (modulus and multiplier constants) and challenge_response_key_mixer.
`timescale 1ns / 1ps

module challenge_response_key_mixer_tb;

   localparam bit [63:0] MixModulus = 64'(crkm_pkg::MixPrime);
   localparam bit [63:0] WordMult   = 64'(crkm_pkg::MixMult);
   localparam int        RandomPairs = 400;
   localparam int        CalmTail    = 40;
   localparam int        CycleLimit  = 400000;
   localparam int        DrainCycles = 40;

   typedef struct {
      bit [63:0] digest_upper;
      bit [63:0] digest_lower;
      bit [30:0] word_first;
      bit [30:0] word_second;
      bit        run_start;
      bit        run_end;
   } challenge_pair_type;

   typedef struct {
      bit [63:0] upper;
      bit [63:0] lower;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_digest_upper = '0;
   logic [63:0] req_digest_lower = '0;
   logic [30:0] req_word_first = '0;
   logic [30:0] req_word_second = '0;
   logic        req_run_start = 1'b0;
   logic        req_run_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_response_upper;
   logic [63:0] rsp_response_lower;

   challenge_pair_type pending_pairs[$];
   response_type       expected_responses[$];
   challenge_pair_type next_pair;
   challenge_pair_type seen_pair;
   response_type       want;

   // model state
   bit [63:0] chal_key[4];
   bit [63:0] latched_digest[2];
   bit [30:0] run_high;
   bit [63:0] run_sum;

   int  total_pairs = 0;
   int  pairs_accepted = 0;
   int  runs_started = 0;
   int  responses_checked = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  pair_taken = 1'b0;
   bit  calm_tail;

   challenge_response_key_mixer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_digest_upper   (req_digest_upper),
      .req_digest_lower   (req_digest_lower),
      .req_word_first     (req_word_first),
      .req_word_second    (req_word_second),
      .req_run_start      (req_run_start),
      .req_run_end        (req_run_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_response_upper (rsp_response_upper),
      .rsp_response_lower (rsp_response_lower)
   );

   always #10 clock = ~clock;

   function automatic bit [31:0] byte_reverse(input bit [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Advance the mixing chain by one pair; queue a response when the run ends
   task automatic mix_pair(input challenge_pair_type p);
      bit [63:0] t;
      bit [63:0] h;
      bit [63:0] hf;
      bit [63:0] sf;
      bit [31:0] key_src;
      response_type r;
      if (p.run_start) begin
         latched_digest[0] = p.digest_upper;
         latched_digest[1] = p.digest_lower;
         key_src = byte_reverse(p.digest_upper[63:32]);
         chal_key[0] = {33'b0, key_src[30:0]};
         key_src = byte_reverse(p.digest_upper[31:0]);
         chal_key[1] = {33'b0, key_src[30:0]};
         key_src = byte_reverse(p.digest_lower[63:32]);
         chal_key[2] = {33'b0, key_src[30:0]};
         key_src = byte_reverse(p.digest_lower[31:0]);
         chal_key[3] = {33'b0, key_src[30:0]};
         run_high = '0;
         run_sum = '0;
      end
      t = ({33'b0, p.word_first} * WordMult) % MixModulus + {33'b0, run_high};
      t = (t * chal_key[0] + chal_key[1]) % MixModulus;
      h = ({33'b0, p.word_second} + t) % MixModulus;
      h = (h * chal_key[2] + chal_key[3]) % MixModulus;
      run_high = h[30:0];
      run_sum = run_sum + h + t;
      if (p.run_end) begin
         hf = ({33'b0, run_high} + chal_key[1]) % MixModulus;
         sf = (run_sum + chal_key[3]) % MixModulus;
         r.upper = latched_digest[0] ^ {byte_reverse(hf[31:0]), byte_reverse(sf[31:0])};
         r.lower = latched_digest[1] ^ {byte_reverse(hf[31:0]), byte_reverse(sf[31:0])};
         expected_responses.push_back(r);
      end
   endtask

   task automatic add_pair(input bit [63:0] du, input bit [63:0] dl, input bit [30:0] w0,
                           input bit [30:0] w1, input bit rs, input bit re);
      challenge_pair_type p;
      p.digest_upper = du;
      p.digest_lower = dl;
      p.word_first   = w0;
      p.word_second  = w1;
      p.run_start    = rs;
      p.run_end      = re;
      pending_pairs.push_back(p);
      total_pairs++;
   endtask

   // Words lean toward zero and the values around the modulus
   function automatic bit [30:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 31'h7FFFFFFF;
         2: return 31'h7FFFFFFE;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic bit [63:0] pick_digest();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Driver: presents the next pending transaction, with random idle bursts
   always @(negedge clock) begin
      if (!reset) begin
         calm_tail = (pending_pairs.size() < CalmTail);
         if (!req_valid || pair_taken) begin
            pair_taken = 1'b0;
            if (send_gap == 0 && !calm_tail && pending_pairs.size() > 0 &&
                $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 10);
            if (send_gap > 0 || pending_pairs.size() == 0) begin
               if (send_gap > 0)
                  send_gap--;
               req_valid <= 1'b0;
            end else begin
               next_pair = pending_pairs.pop_front();
               req_valid        <= 1'b1;
               req_digest_upper <= next_pair.digest_upper;
               req_digest_lower <= next_pair.digest_lower;
               req_word_first   <= next_pair.word_first;
               req_word_second  <= next_pair.word_second;
               req_run_start    <= next_pair.run_start;
               req_run_end      <= next_pair.run_end;
            end
         end
         // receiver stall bursts
         if (stall_left == 0 && !calm_tail && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 10);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: feeds accepted pairs to the model and checks every response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_pair.digest_upper = req_digest_upper;
            seen_pair.digest_lower = req_digest_lower;
            seen_pair.word_first   = req_word_first;
            seen_pair.word_second  = req_word_second;
            seen_pair.run_start    = req_run_start;
            seen_pair.run_end      = req_run_end;
            mix_pair(seen_pair);
            if (req_run_start)
               runs_started++;
            pairs_accepted++;
            pair_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, got %h %h", $time,
                        rsp_response_upper, rsp_response_lower);
            end else begin
               want = expected_responses.pop_front();
               responses_checked++;
               if (rsp_response_upper !== want.upper) begin
                  error_count++;
                  $display("%0t: response_upper mismatch, expected %h, got %h", $time,
                           want.upper, rsp_response_upper);
               end
               if (rsp_response_lower !== want.lower) begin
                  error_count++;
                  $display("%0t: response_lower mismatch, expected %h, got %h", $time,
                           want.lower, rsp_response_lower);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout, %0d of %0d pairs taken, %0d responses outstanding", $time,
                  pairs_accepted, total_pairs, expected_responses.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus and end of test
   initial begin
      int random_count;
      int run_len;
      bit rs;
      bit re;
      random_count = 0;

      // directed: pair with no run started yet, so all-zero keys
      add_pair(pick_digest(), pick_digest(), 31'h1234_5678, 31'h7FFFFFFF, 1'b0, 1'b1);
      // single-pair runs at the extremes, one with words equal to the modulus
      add_pair('1, '1, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1);
      add_pair('0, '0, '0, '0, 1'b1, 1'b1);
      add_pair(64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F, 31'h7FFFFFFE, '0, 1'b1, 1'b1);
      // three-pair run; digests on later pairs must be ignored
      add_pair(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 31'h7FFFFFFE, 31'h1,
               1'b1, 1'b0);
      add_pair('1, '1, 31'h1, 31'h7FFFFFFE, 1'b0, 1'b0);
      add_pair('0, '0, 31'h7FFFFFFF, 31'h7FFFFFFE, 1'b0, 1'b1);
      // continue the chain after an end without a new start
      add_pair(pick_digest(), pick_digest(), 31'h4F4B_4F4B, 31'h2020_2020, 1'b0, 1'b1);
      add_pair(pick_digest(), pick_digest(), pick_word(), pick_word(), 1'b0, 1'b0);
      add_pair(pick_digest(), pick_digest(), pick_word(), pick_word(), 1'b0, 1'b1);
      // abandoned run restarted by a second start
      add_pair(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 31'h7FFFFFFE, 31'h7FFFFFFE,
               1'b1, 1'b0);
      add_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFFFFFE, 31'h7FFFFFFE,
               1'b1, 1'b0);
      add_pair('0, '0, 31'h7FFFFFFE, 31'h7FFFFFFE, 1'b0, 1'b0);
      add_pair('0, '0, 31'h7FFFFFFE, 31'h7FFFFFFE, 1'b0, 1'b0);
      add_pair('0, '0, 31'h7FFFFFFE, 31'h7FFFFFFE, 1'b0, 1'b1);

      // random: mostly well-formed runs, some stray flag combinations
      while (random_count < RandomPairs) begin
         if ($urandom_range(0, 9) == 0) begin
            add_pair(pick_digest(), pick_digest(), pick_word(), pick_word(),
                     1'($urandom), 1'($urandom));
            random_count++;
         end else begin
            run_len = $urandom_range(1, 6);
            for (int i = 0; i < run_len; i++) begin
               rs = (i == 0);
               re = (i == run_len - 1);
               add_pair(pick_digest(), pick_digest(), pick_word(), pick_word(), rs, re);
            end
            random_count += run_len;
         end
      end

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      while (pairs_accepted < total_pairs || expected_responses.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_responses.size() > 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_responses.size());
      end

      $display("Sent %0d challenge pairs in %0d started runs; %0d responses compared.",
               pairs_accepted, runs_started, responses_checked);
      $display("Mismatch and protocol errors: %0d", error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/crkm_pkg.sv
rtl/crkm_seq.sv
rtl/challenge_response_key_mixer.sv
bench/challenge_response_key_mixer_tb.sv
